// ----- rtl/prefix_tree_word_store_defines.svh -----
// Assertion macros for the prefix tree word store.
// Used by the RTL files that carry concurrent checks; needs a clk and rst in scope.
`ifndef PREFIX_TREE_WORD_STORE_DEFINES_SVH
`define PREFIX_TREE_WORD_STORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/pts_pkg.sv -----
// Shared constants and types for the prefix tree word store.
// No dependencies; imported by the top level.
package pts_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int ALPHABET_SIZE = 26;

  localparam int NODE_W   = $clog2(NODE_COUNT);
  localparam int FREE_W   = NODE_W + 1;
  localparam int LETTER_W = 5;
  localparam int OP_W     = 2;
  localparam int ROW_W    = ALPHABET_SIZE * NODE_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_PREFIX = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_MARK
  } state_t;

endpackage

// ----- rtl/pts_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data; read data holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/prefix_tree_word_store.sv -----
// Top level of the prefix tree word store: walk control, allocation and result register.
// Depends on pts_pkg, pts_ram and prefix_tree_word_store_defines.svh.
`include "prefix_tree_word_store_defines.svh"

// Prefix tree over a letter alphabet, held in a pool of NODE_COUNT nodes. Each node is one
// row of the link RAM, with one child field per letter; a separate RAM holds word-end marks.
// Words arrive one letter per request; a request with last_letter set gives one result.
// A letter is handled as a registered read of the cursor node's row, then a pick or allocation
// of the child link with the row written back. The last letter of an exact search also needs
// a second registered read, of the child's word-end mark. A result waiting
// at the output does not block letters that give no result. After reset both RAMs are cleared
// one row per cycle, all NODE_COUNT (1024) rows, with in_ready low.
module prefix_tree_word_store
  import pts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     operation,
  input  logic [LETTER_W-1:0] letter,
  input  logic                last_letter,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                found,
  output logic                pool_full
);

  state_t state, state_next;

  logic [NODE_W-1:0]   clr_cnt;
  logic [NODE_W-1:0]   cursor, cursor_next;
  logic [FREE_W-1:0]   next_free, next_free_next;
  logic                missing, missing_next;
  logic                exhausted, exhausted_next;

  logic [OP_W-1:0]     op_q;
  logic [LETTER_W-1:0] letter_q;
  logic                last_q;

  logic                child_wr_en, child_rd_en;
  logic [NODE_W-1:0]   child_wr_addr;
  logic [ROW_W-1:0]    child_wr_data, rd_row, row_new;
  logic                mark_wr_en, mark_wr_data, mark_rd_en, mark_rd;
  logic [NODE_W-1:0]   mark_wr_addr, mark_rd_addr;

  logic                letter_ok, alloc, step_miss, step_exh, need_mark, can_emit;
  logic [NODE_W-1:0]   child, step_cur;
  logic                emit, emit_found, emit_full;

  pts_ram #(.WIDTH(ROW_W), .DEPTH(NODE_COUNT)) u_links (
    .clk     (clk),
    .wr_en   (child_wr_en),
    .wr_addr (child_wr_addr),
    .wr_data (child_wr_data),
    .rd_en   (child_rd_en),
    .rd_addr (cursor),
    .rd_data (rd_row)
  );

  pts_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_marks (
    .clk     (clk),
    .wr_en   (mark_wr_en),
    .wr_addr (mark_wr_addr),
    .wr_data (mark_wr_data),
    .rd_en   (mark_rd_en),
    .rd_addr (mark_rd_addr),
    .rd_data (mark_rd)
  );

  assign in_ready = (state == ST_IDLE);
  assign can_emit = !out_valid || out_ready;

  // Select the child link of the held letter and build the row with a fresh link
  always_comb begin
    letter_ok = (32'(letter_q) < ALPHABET_SIZE);
    child     = '0;
    row_new   = rd_row;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (32'(letter_q) == i) begin
        child                          = rd_row[i*NODE_W +: NODE_W];
        row_new[i*NODE_W +: NODE_W]    = next_free[NODE_W-1:0];
      end
    end
  end

  // Advance the walk by one letter: follow, allocate, or record a miss or a full pool
  always_comb begin
    step_cur  = cursor;
    step_miss = missing;
    step_exh  = exhausted;
    alloc     = 1'b0;
    if (!missing && !exhausted) begin
      if (!letter_ok) begin
        step_miss = 1'b1;
      end else if (child == '0) begin
        if (op_q != OP_INSERT) begin
          step_miss = 1'b1;
        end else if (next_free >= FREE_W'(NODE_COUNT)) begin
          step_exh = 1'b1;
        end else begin
          alloc    = 1'b1;
          step_cur = next_free[NODE_W-1:0];
        end
      end else begin
        step_cur = child;
      end
    end
    need_mark = (op_q == OP_SEARCH) && !step_miss && !step_exh;
  end

  // Next state, memory controls and result
  always_comb begin
    state_next     = state;
    cursor_next    = cursor;
    next_free_next = next_free;
    missing_next   = missing;
    exhausted_next = exhausted;
    child_rd_en    = 1'b0;
    child_wr_en    = 1'b0;
    child_wr_addr  = cursor;
    child_wr_data  = row_new;
    mark_wr_en     = 1'b0;
    mark_wr_addr   = step_cur;
    mark_wr_data   = 1'b1;
    mark_rd_en     = 1'b0;
    mark_rd_addr   = step_cur;
    emit           = 1'b0;
    emit_found     = 1'b0;
    emit_full      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        child_wr_en   = 1'b1;
        child_wr_addr = clr_cnt;
        child_wr_data = '0;
        mark_wr_en    = 1'b1;
        mark_wr_addr  = clr_cnt;
        mark_wr_data  = 1'b0;
        if (clr_cnt == NODE_W'(NODE_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          child_rd_en = 1'b1;
          state_next  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!last_q || need_mark || can_emit) begin
          child_wr_en = alloc;
          if (alloc) begin
            next_free_next = next_free + FREE_W'(1);
          end
          state_next = ST_IDLE;
          if (!last_q) begin
            cursor_next    = step_cur;
            missing_next   = step_miss;
            exhausted_next = step_exh;
          end else begin
            // End of word: restart the walk at the root
            cursor_next    = '0;
            missing_next   = 1'b0;
            exhausted_next = 1'b0;
            if (need_mark) begin
              mark_rd_en = 1'b1;
              state_next = ST_MARK;
            end else begin
              emit = 1'b1;
              case (op_q)
                OP_INSERT: begin
                  if (step_exh) begin
                    emit_full = 1'b1;
                  end else if (!step_miss) begin
                    mark_wr_en = 1'b1;
                    emit_found = 1'b1;
                  end
                end
                default: emit_found = !step_miss && !step_exh;
              endcase
            end
          end
        end
      end
      ST_MARK: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_found = mark_rd;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      cursor    <= '0;
      next_free <= FREE_W'(1);
      missing   <= 1'b0;
      exhausted <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cursor    <= cursor_next;
      next_free <= next_free_next;
      missing   <= missing_next;
      exhausted <= exhausted_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + NODE_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q     <= operation;
      letter_q <= letter;
      last_q   <= last_letter;
    end
    if (emit) begin
      found     <= emit_found;
      pool_full <= emit_full;
    end
  end

  `PTS_ASSERT(a_no_req_in_clear, (state == ST_CLEAR) |-> !in_ready, "request taken during clear")
  `PTS_ASSERT(a_cursor_allocated, {1'b0, cursor} < next_free, "cursor beyond allocated nodes")
  `PTS_ASSERT(a_link_wr_state, child_wr_en |-> (state == ST_CLEAR || state == ST_LOOK),
              "link RAM written outside clear or lookup")
  `PTS_ASSERT(a_alloc_step,
              (child_wr_en && state == ST_LOOK) |=> next_free == $past(next_free) + FREE_W'(1),
              "allocation did not advance free counter")
  `PTS_ASSERT(a_emit_slot, emit |-> can_emit, "result overwrote a pending result")

endmodule
